FILE: rtl/core/bmf_pkg.sv
// shared types and constants for the bgp message framer
package bmf_pkg;

  localparam int BYTE_WIDTH    = 8;
  localparam int SIZE_WIDTH    = 16;
  localparam int OUT_CNT_WIDTH = 32;
  localparam int NUM_TYPES     = 4;
  localparam int TYPE_IDX_W    = 2;

  // header byte positions and limits
  localparam logic [SIZE_WIDTH-1:0] OFF_LEN_HI = 16'd16;
  localparam logic [SIZE_WIDTH-1:0] OFF_LEN_LO = 16'd17;
  localparam logic [SIZE_WIDTH-1:0] OFF_TYPE   = 16'd18;
  localparam logic [SIZE_WIDTH-1:0] MIN_LENGTH = 16'd19;

  // message type codes
  localparam logic [BYTE_WIDTH-1:0] TYPE_OPEN         = 8'd1;
  localparam logic [BYTE_WIDTH-1:0] TYPE_UPDATE       = 8'd2;
  localparam logic [BYTE_WIDTH-1:0] TYPE_NOTIFICATION = 8'd3;
  localparam logic [BYTE_WIDTH-1:0] TYPE_KEEPALIVE    = 8'd4;

  typedef logic [BYTE_WIDTH-1:0] byte_t;
  typedef logic [SIZE_WIDTH-1:0] size_t;

  typedef struct packed {
    logic  last;
    byte_t kind;
    size_t size;
    logic  err;
  } frame_status_t;

  typedef struct packed {
    logic                  inc;
    logic [TYPE_IDX_W-1:0] idx;
  } count_event_t;

endpackage

FILE: rtl/core/bmf_in_if.sv
// input byte channel
interface bmf_in_if import bmf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

FILE: rtl/core/bmf_out_if.sv
// result channel with byte, framing marks and message counters
interface bmf_out_if import bmf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  byte_t                    byte_out;
  logic                     message_last;
  byte_t                    message_kind;
  size_t                    message_size;
  logic                     sync_error;
  logic [OUT_CNT_WIDTH-1:0] total_messages;
  logic [OUT_CNT_WIDTH-1:0] open_messages;
  logic [OUT_CNT_WIDTH-1:0] update_messages;
  logic [OUT_CNT_WIDTH-1:0] notification_messages;
  logic [OUT_CNT_WIDTH-1:0] keepalive_messages;

  modport source (
    output valid, input ready, output byte_out, output message_last,
    output message_kind, output message_size, output sync_error,
    output total_messages, output open_messages, output update_messages,
    output notification_messages, output keepalive_messages
  );
  modport sink (
    input valid, output ready, input byte_out, input message_last,
    input message_kind, input message_size, input sync_error,
    input total_messages, input open_messages, input update_messages,
    input notification_messages, input keepalive_messages
  );
endinterface

FILE: rtl/core/bgp_message_framer.sv
// bgp message framer top: input stage, parser and counters, result register
// a byte accepted goes first into the input stage register, then into the result register
// throughput: one byte per cycle while the result channel takes results; the result register and input stage let the
//   next byte in while a result waits to be taken
// reset (rst, synchronous): offset, captured fields, sync error and all counters
//   go to zero; both stages empty
module bgp_message_framer import bmf_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  bmf_in_if.sink   in_stream,
  bmf_out_if.source out_stream
);

  logic  stg_valid;
  byte_t stg_byte;
  logic  res_valid;
  logic  advance, step, in_take;

  frame_status_t status_next;
  count_event_t  event_next;

  logic [COUNT_WIDTH-1:0]   total_next;
  logic [COUNT_WIDTH-1:0]   by_type_next [NUM_TYPES];
  logic [OUT_CNT_WIDTH-1:0] total_out;
  logic [OUT_CNT_WIDTH-1:0] by_type_out [NUM_TYPES];

  assign advance = !res_valid || out_stream.ready;
  assign step    = stg_valid && advance;
  assign in_stream.ready = !stg_valid || advance;
  assign in_take = in_stream.valid && in_stream.ready;

  bmf_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (stg_byte),
    .status_next (status_next),
    .event_next  (event_next)
  );

  bmf_counters #(.COUNT_WIDTH(COUNT_WIDTH)) u_counters (
    .clk          (clk),
    .rst          (rst),
    .ev           (event_next),
    .total_next   (total_next),
    .by_type_next (by_type_next)
  );

  // counters show their low 32 bits, zero-extended when COUNT_WIDTH is narrower
  if (COUNT_WIDTH >= OUT_CNT_WIDTH) begin : g_trunc
    always_comb begin
      total_out = total_next[OUT_CNT_WIDTH-1:0];
      for (int i = 0; i < NUM_TYPES; i++) begin
        by_type_out[i] = by_type_next[i][OUT_CNT_WIDTH-1:0];
      end
    end
  end else begin : g_ext
    always_comb begin
      total_out = {{(OUT_CNT_WIDTH-COUNT_WIDTH){1'b0}}, total_next};
      for (int i = 0; i < NUM_TYPES; i++) begin
        by_type_out[i] = {{(OUT_CNT_WIDTH-COUNT_WIDTH){1'b0}}, by_type_next[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_take) begin
        stg_valid <= 1'b1;
      end else if (step) begin
        stg_valid <= 1'b0;
      end
      if (step) begin
        res_valid <= 1'b1;
      end else if (out_stream.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_byte <= in_stream.data_byte;
    end
    if (step) begin
      out_stream.byte_out              <= stg_byte;
      out_stream.message_last          <= status_next.last;
      out_stream.message_kind          <= status_next.kind;
      out_stream.message_size          <= status_next.size;
      out_stream.sync_error            <= status_next.err;
      out_stream.total_messages        <= total_out;
      out_stream.open_messages         <= by_type_out[0];
      out_stream.update_messages       <= by_type_out[1];
      out_stream.notification_messages <= by_type_out[2];
      out_stream.keepalive_messages    <= by_type_out[3];
    end
  end

  assign out_stream.valid = res_valid;

endmodule

FILE: rtl/core/bmf_parser.sv
// header parser: byte offset, length and type capture, end-of-message detect
module bmf_parser import bmf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  byte_t         data_byte,
  output frame_status_t status_next,
  output count_event_t  event_next
);

  size_t byte_offset, byte_offset_next;
  size_t length_field, length_field_next;
  byte_t type_field, type_field_next;
  logic  error_flag, error_flag_next;
  logic  bad, last;
  logic  [TYPE_IDX_W-1:0] kind_idx;

  always_comb begin
    byte_offset_next  = byte_offset;
    length_field_next = length_field;
    type_field_next   = type_field;
    error_flag_next   = error_flag;
    bad  = 1'b0;
    last = 1'b0;
    if (!error_flag) begin
      if (byte_offset == OFF_LEN_HI) begin
        length_field_next = {data_byte, {BYTE_WIDTH{1'b0}}};
      end else if (byte_offset == OFF_LEN_LO) begin
        length_field_next = {length_field[SIZE_WIDTH-1:BYTE_WIDTH], data_byte};
        bad = (length_field_next < MIN_LENGTH);
      end else if (byte_offset == OFF_TYPE) begin
        type_field_next = data_byte;
        bad = (data_byte < TYPE_OPEN) || (data_byte > TYPE_KEEPALIVE);
      end
      if (bad) begin
        error_flag_next = 1'b1;
      end else if (byte_offset >= OFF_TYPE &&
                   ({1'b0, byte_offset} + 17'd1) == {1'b0, length_field_next}) begin
        last = 1'b1;
        byte_offset_next = '0;
      end else begin
        byte_offset_next = byte_offset + 16'd1;
      end
    end
  end

  // type 1..4 maps to counter slot 0..3
  assign kind_idx = type_field_next[TYPE_IDX_W-1:0] - TYPE_OPEN[TYPE_IDX_W-1:0];

  assign status_next = '{last: last, kind: type_field_next, size: length_field_next,
                         err: error_flag_next};
  assign event_next  = '{inc: step & last, idx: kind_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      length_field <= '0;
      type_field   <= '0;
      error_flag   <= 1'b0;
    end else if (step) begin
      byte_offset  <= byte_offset_next;
      length_field <= length_field_next;
      type_field   <= type_field_next;
      error_flag   <= error_flag_next;
    end
  end

endmodule

FILE: rtl/core/bmf_counters.sv
// wrapping message counters: total and one per message type
module bmf_counters import bmf_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  count_event_t           ev,
  output logic [COUNT_WIDTH-1:0] total_next,
  output logic [COUNT_WIDTH-1:0] by_type_next [NUM_TYPES]
);

  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] by_type [NUM_TYPES];

  always_comb begin
    total_next = ev.inc ? total + COUNT_WIDTH'(1) : total;
    for (int i = 0; i < NUM_TYPES; i++) begin
      by_type_next[i] = (ev.inc && ev.idx == TYPE_IDX_W'(i)) ?
                        by_type[i] + COUNT_WIDTH'(1) : by_type[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        by_type[i] <= '0;
      end
    end else begin
      total <= total_next;
      for (int i = 0; i < NUM_TYPES; i++) begin
        by_type[i] <= by_type_next[i];
      end
    end
  end

endmodule

FILE: verif/bmf_frame_checker.sv
// framing predictor and result comparison for the bgp message framer
`timescale 1ns / 100ps

module bmf_frame_checker import bmf_pkg::*; (
  input  logic clk,
  input  logic rst,
  bmf_in_if    in_ch,
  bmf_out_if   out_ch,
  output int   failures,
  output int   pending,
  output int   framed
);

  typedef struct packed {
    byte_t                    data;
    logic                     last;
    byte_t                    kind;
    size_t                    size;
    logic                     err;
    logic [OUT_CNT_WIDTH-1:0] total;
    logic [OUT_CNT_WIDTH-1:0] opens;
    logic [OUT_CNT_WIDTH-1:0] updates;
    logic [OUT_CNT_WIDTH-1:0] notes;
    logic [OUT_CNT_WIDTH-1:0] keepalives;
  } framed_byte_t;

  // framer state as the block should hold it
  size_t                    frame_offset;
  size_t                    frame_len;
  byte_t                    frame_kind;
  logic                     framing_lost;
  logic [OUT_CNT_WIDTH-1:0] msg_total;
  logic [OUT_CNT_WIDTH-1:0] msg_by_kind [NUM_TYPES];

  framed_byte_t predicted_bytes [$];

  function automatic framed_byte_t frame_next_byte(byte_t b);
    framed_byte_t          r;
    logic                  bad;
    size_t                 off;
    logic [TYPE_IDX_W-1:0] k;
    r.last = 1'b0;
    if (!framing_lost) begin
      bad = 1'b0;
      off = frame_offset;
      if (off == OFF_LEN_HI) begin
        frame_len = {b, 8'h00};
      end else if (off == OFF_LEN_LO) begin
        frame_len = {frame_len[15:8], b};
        if (frame_len < MIN_LENGTH) bad = 1'b1;
      end else if (off == OFF_TYPE) begin
        frame_kind = b;
        if (b < TYPE_OPEN || b > TYPE_KEEPALIVE) bad = 1'b1;
      end
      if (bad) begin
        framing_lost = 1'b1;
      end else if (off >= OFF_TYPE && 32'(off) + 32'd1 == 32'(frame_len)) begin
        r.last = 1'b1;
        k = TYPE_IDX_W'(frame_kind - TYPE_OPEN);
        msg_total = msg_total + 1'b1;
        msg_by_kind[k] = msg_by_kind[k] + 1'b1;
        frame_offset = '0;
      end else begin
        frame_offset = off + 1'b1;
      end
    end
    r.data       = b;
    r.kind       = frame_kind;
    r.size       = frame_len;
    r.err        = framing_lost;
    r.total      = msg_total;
    r.opens      = msg_by_kind[0];
    r.updates    = msg_by_kind[1];
    r.notes      = msg_by_kind[2];
    r.keepalives = msg_by_kind[3];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0h got %0h", $time, name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    framed_byte_t e;
    if (rst) begin
      frame_offset = '0;
      frame_len    = '0;
      frame_kind   = '0;
      framing_lost = 1'b0;
      msg_total    = '0;
      for (int i = 0; i < NUM_TYPES; i++) msg_by_kind[i] = '0;
      predicted_bytes.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        predicted_bytes.push_back(frame_next_byte(in_ch.data_byte));
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_bytes.size() == 0) begin
          $display("%0t unexpected result transaction: byte %0h", $time, out_ch.byte_out);
          failures++;
        end else begin
          e = predicted_bytes.pop_front();
          check_field("byte_out", e.data, out_ch.byte_out);
          check_field("message_last", e.last, out_ch.message_last);
          check_field("message_kind", e.kind, out_ch.message_kind);
          check_field("message_size", e.size, out_ch.message_size);
          check_field("sync_error", e.err, out_ch.sync_error);
          check_field("total_messages", e.total, out_ch.total_messages);
          check_field("open_messages", e.opens, out_ch.open_messages);
          check_field("update_messages", e.updates, out_ch.update_messages);
          check_field("notification_messages", e.notes, out_ch.notification_messages);
          check_field("keepalive_messages", e.keepalives, out_ch.keepalive_messages);
        end
      end
    end
    pending = predicted_bytes.size();
    framed  = msg_total;
  end

endmodule

FILE: verif/tb_bgp_message_framer.sv
// stimulus, handshake pacing and verdict for the bgp message framer
`timescale 1ns / 100ps

module tb_bgp_message_framer import bmf_pkg::*;;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst;

  bmf_in_if  in_ch ();
  bmf_out_if out_ch ();

  int failures;
  int pending;
  int framed;
  int bytes_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  bit short_len_err;

  bgp_message_framer #(.COUNT_WIDTH(32)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_ch),
    .out_stream (out_ch)
  );

  bmf_frame_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .failures (failures),
    .pending  (pending),
    .framed   (framed)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAIL bgp_message_framer");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_byte(byte_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // marker and body bytes take fill, or random values when fill is negative
  task automatic send_message(size_t len, byte_t kind, int fill);
    for (int i = 0; i < 16; i++)
      send_byte(fill < 0 ? byte_t'($urandom) : byte_t'(fill));
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(kind);
    for (int i = 19; i < int'(len); i++)
      send_byte(fill < 0 ? byte_t'($urandom) : byte_t'(fill));
  endtask

  task automatic random_messages(int n_bytes);
    int    stop_at;
    int    r;
    size_t len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(15);
      if (r == 0)      len = MIN_LENGTH;
      else if (r == 1) len = size_t'($urandom_range(65, 300));
      else             len = size_t'($urandom_range(19, 64));
      send_message(len, byte_t'($urandom_range(1, 4)), -1);
    end
  endtask

  // hold the sender off until every result is back
  task automatic drain;
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: each type, shortest length, byte-boundary length, fill extremes
    send_message(MIN_LENGTH, TYPE_KEEPALIVE, 8'hff);
    send_message(MIN_LENGTH, TYPE_OPEN, 8'h00);
    send_message(16'd20, TYPE_UPDATE, 8'hff);
    send_message(16'd256, TYPE_NOTIFICATION, -1);
    send_message(16'd21, TYPE_KEEPALIVE, 8'ha5);
    drain();

    random_messages(110);
    drain();

    send_idle_pct = 45;
    recv_stall_pct = 0;
    random_messages(110);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 45;
    random_messages(110);
    drain();

    send_idle_pct = 24;
    recv_stall_pct = 24;
    random_messages(110);

    // break framing: either a short length or a type outside the known set
    short_len_err = 1'($urandom_range(1));
    for (int i = 0; i < 16; i++) send_byte(byte_t'($urandom));
    send_byte(8'h00);
    if (short_len_err) begin
      send_byte(byte_t'($urandom_range(0, 18)));
    end else begin
      send_byte(byte_t'($urandom_range(19, 255)));
      send_byte($urandom_range(1) ? 8'h00 : byte_t'($urandom_range(5, 255)));
    end
    // framing is lost now: noise and a well-formed message must not be counted
    for (int i = 0; i < 30; i++) send_byte(byte_t'($urandom));
    send_message(MIN_LENGTH, TYPE_KEEPALIVE, -1);

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);

    $display("covered %0d stream bytes over four pacing patterns, %0d messages framed",
             bytes_sent, framed);
    $display("framing then broken by a %s", short_len_err ? "short length" : "bad type");
    if (failures == 0) begin
      $display("PASS bgp_message_framer");
    end else begin
      $display("FAIL bgp_message_framer");
    end
    $finish;
  end

endmodule
